// ----- rtl/core/stod_pkg.sv -----
`timescale 1ns / 1ps

package stod_pkg;

    localparam int SCALE_W = 32;
    localparam int QUOT_W  = 16;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int UNTIL_W = 11;
    localparam int S_DATA_W = 56;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 40;
    localparam int ADDR_W   = 3;
    localparam int PDATA_W  = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET    = 32'd1000;
    localparam logic [HOUR_W-1:0]  RESET_HOUR     = 5'd12;
    localparam logic [HOUR_W-1:0]  HOURS_PER_DAY  = 5'd24;
    localparam logic [MIN_W:0]     MINS_PER_HOUR  = 7'd60;
    localparam logic [MIN_W:0]     FF_MINUTES     = 7'd8;
    localparam logic [MIN_W:0]     ONE_MINUTE     = 7'd1;
    localparam logic [11:0]        MINS_PER_DAY   = 12'd1440;

    // register index taken from paddr[2]
    localparam logic REG_IDX_SCALE = 1'b0;

    typedef enum logic [2:0] {
        MODE_TICK    = 3'd0,
        MODE_SET     = 3'd1,
        MODE_STORE   = 3'd2,
        MODE_RESTORE = 3'd3,
        MODE_UNTIL   = 3'd4,
        MODE_RANGE   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ELAP,
        ST_SCALE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                   start;
        logic [SCALE_W-1:0]     dividend;
        logic [SCALE_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [QUOT_W-1:0]      quot;
    } div_rsp_t;

endpackage

// ----- rtl/core/stod_div.sv -----
`timescale 1ns / 1ps

module stod_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  stod_pkg::div_req_t req,
    output stod_pkg::div_rsp_t rsp
);
    import stod_pkg::*;

    logic [SCALE_W-1:0] rem_reg, rem_next;
    logic [SCALE_W-1:0] quo_reg, quo_next;
    logic [SCALE_W-1:0] dsr_reg, dsr_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [SCALE_W:0]   trial;
    logic [SCALE_W:0]   diff;
    logic               ge;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial     = {rem_reg, quo_reg[SCALE_W-1]};
        diff      = trial - {1'b0, dsr_reg};
        ge        = (trial >= {1'b0, dsr_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
            quo_next = {quo_reg[SCALE_W-2:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg[QUOT_W-1:0];

endmodule

// ----- rtl/core/scaled_time_of_day_clock_core.sv -----
// Hours:minutes clock whose minute lasts ms_per_minute input milliseconds.
// One result item leaves for each input item. A tick's result passes through
// the EXEC, ELAP, SCALE, DIV and OUT states; in DIV the bit-serial divider
// forms the seconds value one quotient bit per cycle. Every other operation
// goes from EXEC straight to OUT. The next item can be accepted in the cycle
// after the previous result has moved to the output register, which holds
// that result until it is taken.
`timescale 1ns / 1ps

module scaled_time_of_day_clock_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // now_ms, fast_forward, hour_arg, minute_arg, hour_end, zero fill
    input  logic [stod_pkg::S_DATA_W-1:0] s_tdata,
    // mode
    input  logic [stod_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hours, minutes, seconds, minutes_until, in_range, clock_saved
    output logic [stod_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stod_pkg::ADDR_W-1:0]   paddr,
    input  logic [stod_pkg::PDATA_W-1:0]  pwdata,
    output logic [stod_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import stod_pkg::*;

    state_t             state_reg, state_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [HOUR_W-1:0]  hour_reg, hour_next;
    logic [MIN_W-1:0]   min_reg, min_next;
    logic [QUOT_W-1:0]  sec_reg, sec_next;
    logic [SCALE_W-1:0] last_reg, last_next;
    logic [HOUR_W-1:0]  sv_hour_reg, sv_hour_next;
    logic [MIN_W-1:0]   sv_min_reg, sv_min_next;
    logic [QUOT_W-1:0]  sv_sec_reg, sv_sec_next;
    logic               saved_reg, saved_next;
    mode_t              mode_reg, mode_next;
    logic [SCALE_W-1:0] now_reg, now_next;
    logic               ff_reg, ff_next;
    logic [HOUR_W-1:0]  harg_reg, harg_next;
    logic [MIN_W-1:0]   marg_reg, marg_next;
    logic [HOUR_W-1:0]  hend_reg, hend_next;
    logic [SCALE_W-1:0] elap_reg, elap_next;
    logic [UNTIL_W-1:0] until_reg, until_next;
    logic               inr_reg, inr_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [SCALE_W-1:0] elapsed;
    logic [MIN_W:0]     new_min;
    logic               do_roll;
    logic [HOUR_W-1:0]  hour_inc;
    logic [11:0]        cur_min;
    logic [11:0]        then_min;
    logic [11:0]        until_diff;
    logic               cfg_wr;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    stod_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDX_SCALE) ? scale_reg : '0;

    always_comb begin
        elapsed    = now_reg - last_reg;
        hour_inc   = hour_reg + 5'd1;
        cur_min    = 12'({hour_reg, 6'b0}) - 12'({hour_reg, 2'b0}) + 12'(min_reg);
        then_min   = 12'({harg_reg, 6'b0}) - 12'({harg_reg, 2'b0}) + 12'(marg_reg);
        if (then_min < cur_min) begin
            then_min = then_min + MINS_PER_DAY;
        end
        until_diff = then_min - cur_min;
        new_min    = ff_reg ? ({1'b0, min_reg} + FF_MINUTES) : ({1'b0, min_reg} + ONE_MINUTE);
        do_roll    = ff_reg || (elapsed > scale_reg);

        state_next    = state_reg;
        scale_next    = cfg_wr && (paddr[2] == REG_IDX_SCALE) ? pwdata : scale_reg;
        hour_next     = hour_reg;
        min_next      = min_reg;
        sec_next      = sec_reg;
        last_next     = last_reg;
        sv_hour_next  = sv_hour_reg;
        sv_min_next   = sv_min_reg;
        sv_sec_next   = sv_sec_reg;
        saved_next    = saved_reg;
        mode_next     = mode_reg;
        now_next      = now_reg;
        ff_next       = ff_reg;
        harg_next     = harg_reg;
        marg_next     = marg_reg;
        hend_next     = hend_reg;
        elap_next     = elap_reg;
        until_next    = until_reg;
        inr_next      = inr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        s_tready      = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {elap_reg[25:0], 6'b0} - {elap_reg[29:0], 2'b0};
        div_req.divisor  = scale_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    mode_next  = mode_t'(s_tuser);
                    now_next   = s_tdata[31:0];
                    ff_next    = s_tdata[32];
                    harg_next  = s_tdata[37:33];
                    marg_next  = s_tdata[43:38];
                    hend_next  = s_tdata[48:44];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                until_next = '0;
                inr_next   = 1'b0;
                state_next = ST_OUT;
                unique case (mode_reg)
                    MODE_TICK: begin
                        state_next = ST_ELAP;
                        if (do_roll) begin
                            last_next = ff_reg ? now_reg : (last_reg + scale_reg);
                            if (new_min >= MINS_PER_HOUR) begin
                                min_next  = '0;
                                hour_next = (hour_inc >= HOURS_PER_DAY) ? '0 : hour_inc;
                            end else begin
                                min_next = new_min[MIN_W-1:0];
                            end
                        end
                    end
                    MODE_SET: begin
                        hour_next = harg_reg;
                        min_next  = marg_reg;
                        sec_next  = '0;
                        last_next = now_reg;
                    end
                    MODE_STORE: begin
                        sv_hour_next = hour_reg;
                        sv_min_next  = min_reg;
                        sv_sec_next  = sec_reg;
                        saved_next   = 1'b1;
                    end
                    MODE_RESTORE: begin
                        hour_next = sv_hour_reg;
                        min_next  = sv_min_reg;
                        sec_next  = sv_sec_reg;
                    end
                    MODE_UNTIL: begin
                        until_next = until_diff[UNTIL_W-1:0];
                    end
                    MODE_RANGE: begin
                        if (harg_reg > hend_reg) begin
                            inr_next = (hour_reg >= harg_reg) || (hour_reg < hend_reg);
                        end else begin
                            inr_next = (hour_reg >= harg_reg) && (hour_reg < hend_reg);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_ELAP: begin
                elap_next  = elapsed;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    sec_next   = div_rsp.quot;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {saved_reg, inr_reg, until_reg, sec_reg, min_reg, hour_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scale_reg    <= SCALE_RESET;
            hour_reg     <= RESET_HOUR;
            min_reg      <= '0;
            sec_reg      <= '0;
            last_reg     <= '0;
            sv_hour_reg  <= '0;
            sv_min_reg   <= '0;
            sv_sec_reg   <= '0;
            saved_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scale_reg    <= scale_next;
            hour_reg     <= hour_next;
            min_reg      <= min_next;
            sec_reg      <= sec_next;
            last_reg     <= last_next;
            sv_hour_reg  <= sv_hour_next;
            sv_min_reg   <= sv_min_next;
            sv_sec_reg   <= sv_sec_next;
            saved_reg    <= saved_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        mode_reg    <= mode_next;
        now_reg     <= now_next;
        ff_reg      <= ff_next;
        harg_reg    <= harg_next;
        marg_reg    <= marg_next;
        hend_reg    <= hend_next;
        elap_reg    <= elap_next;
        until_reg   <= until_next;
        inr_reg     <= inr_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item still in progress");

    a_div_done_moves_on: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && div_rsp.done |=> state_reg == ST_OUT)
        else $error("divider result not taken");

    a_query_results_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[38] && (m_tdata[37:27] != '0)))
        else $error("range and minutes-until results both set");

    a_saved_flag_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        saved_reg |=> saved_reg)
        else $error("store flag cleared outside reset");

endmodule

// ----- tb/scaled_time_of_day_clock_core_test.sv -----
`timescale 1ns / 1ps

module scaled_time_of_day_clock_core_test;
    import stod_pkg::*;

    localparam logic [2:0]        MODE_SPARE_6 = 3'd6;
    localparam logic [2:0]        MODE_SPARE_7 = 3'd7;
    localparam logic [ADDR_W-1:0] SCALE_ADDR   = {REG_IDX_SCALE, 2'b00};
    localparam int                IDLE_PCT     = 15;
    localparam int                STALL_LIMIT  = 2000;
    localparam int                DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [2:0]        mode;
        logic [31:0]       now_ms;
        logic              fast_forward;
        logic [HOUR_W-1:0] hour_arg;
        logic [MIN_W-1:0]  minute_arg;
        logic [HOUR_W-1:0] hour_end;
    } clock_cmd_t;

    // msb first, so hours land in the low bits of m_tdata
    typedef struct packed {
        logic               clock_saved;
        logic               in_range;
        logic [UNTIL_W-1:0] minutes_until;
        logic [QUOT_W-1:0]  seconds;
        logic [MIN_W-1:0]   minutes;
        logic [HOUR_W-1:0]  hours;
    } clock_report_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    scaled_time_of_day_clock_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // clock state as the block should hold it
    logic [SCALE_W-1:0] scale_ms    = SCALE_RESET;
    logic [HOUR_W-1:0]  hour_now    = RESET_HOUR;
    logic [MIN_W-1:0]   minute_now  = '0;
    logic [QUOT_W-1:0]  second_now  = '0;
    logic [31:0]        tick_mark   = '0;
    logic [HOUR_W-1:0]  kept_hour   = '0;
    logic [MIN_W-1:0]   kept_minute = '0;
    logic [QUOT_W-1:0]  kept_second = '0;
    logic               kept_valid  = 1'b0;

    clock_cmd_t    items_to_send[$];
    clock_report_t clock_reports_due[$];
    clock_cmd_t    cmd_on_bus;
    int            issued_count   = 0;
    int            accepted_count = 0;
    int            errors         = 0;
    int            quiet_cycles   = 0;
    bit            steady         = 1'b0;
    logic [31:0]   stim_ms        = '0;

    function automatic void roll_minutes(logic [31:0] total);
        if (total >= 32'(MINS_PER_HOUR)) begin
            minute_now = '0;
            hour_now   = hour_now + 1'b1;
            if (hour_now >= HOURS_PER_DAY) begin
                hour_now = '0;
            end
        end else begin
            minute_now = total[MIN_W-1:0];
        end
    endfunction

    function automatic clock_report_t advance_clock(clock_cmd_t cmd);
        logic [31:0]   elapsed;
        logic [31:0]   quot;
        logic [31:0]   cur_min;
        logic [31:0]   later_min;
        logic [31:0]   diff;
        clock_report_t rep;
        rep = '0;
        case (cmd.mode)
            MODE_TICK: begin
                elapsed = cmd.now_ms - tick_mark;
                if (cmd.fast_forward) begin
                    tick_mark = cmd.now_ms;
                    roll_minutes(32'(minute_now) + 32'(FF_MINUTES));
                end else if (elapsed > scale_ms) begin
                    tick_mark = tick_mark + scale_ms;
                    roll_minutes(32'(minute_now) + 32'(ONE_MINUTE));
                end
                elapsed = cmd.now_ms - tick_mark;
                quot = (scale_ms != '0) ? (elapsed * 32'(MINS_PER_HOUR)) / scale_ms : '1;
                second_now = quot[QUOT_W-1:0];
            end
            MODE_SET: begin
                hour_now   = cmd.hour_arg;
                minute_now = cmd.minute_arg;
                second_now = '0;
                tick_mark  = cmd.now_ms;
            end
            MODE_STORE: begin
                kept_hour   = hour_now;
                kept_minute = minute_now;
                kept_second = second_now;
                kept_valid  = 1'b1;
            end
            MODE_RESTORE: begin
                hour_now   = kept_hour;
                minute_now = kept_minute;
                second_now = kept_second;
            end
            MODE_UNTIL: begin
                cur_min   = 32'(hour_now) * 32'(MINS_PER_HOUR) + 32'(minute_now);
                later_min = 32'(cmd.hour_arg) * 32'(MINS_PER_HOUR) + 32'(cmd.minute_arg);
                if (later_min < cur_min) begin
                    later_min = later_min + 32'(MINS_PER_DAY);
                end
                diff = later_min - cur_min;
                rep.minutes_until = diff[UNTIL_W-1:0];
            end
            MODE_RANGE: begin
                if (cmd.hour_arg > cmd.hour_end) begin
                    rep.in_range = (hour_now >= cmd.hour_arg) || (hour_now < cmd.hour_end);
                end else begin
                    rep.in_range = (hour_now >= cmd.hour_arg) && (hour_now < cmd.hour_end);
                end
            end
            default: begin
            end
        endcase
        rep.hours       = hour_now;
        rep.minutes     = minute_now;
        rep.seconds     = second_now;
        rep.clock_saved = kept_valid;
        return rep;
    endfunction

    function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                clock_reports_due.push_back(advance_clock(cmd_on_bus));
                accepted_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (items_to_send.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cmd_on_bus = items_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_DATA_W'({cmd_on_bus.hour_end, cmd_on_bus.minute_arg,
                                           cmd_on_bus.hour_arg, cmd_on_bus.fast_forward,
                                           cmd_on_bus.now_ms});
                    s_tuser  <= cmd_on_bus.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        clock_report_t seen;
        clock_report_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen = clock_report_t'(m_tdata);
                if (clock_reports_due.size() == 0) begin
                    $display("%0t ns: unexpected item, expected none, actual %h", $time, seen);
                    errors++;
                end else begin
                    want = clock_reports_due.pop_front();
                    compare_field("hours", want.hours, seen.hours);
                    compare_field("minutes", want.minutes, seen.minutes);
                    compare_field("seconds", want.seconds, seen.seconds);
                    compare_field("minutes_until", want.minutes_until, seen.minutes_until);
                    compare_field("in_range", want.in_range, seen.in_range);
                    compare_field("clock_saved", want.clock_saved, seen.clock_saved);
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_scale(logic [SCALE_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SCALE_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        scale_ms = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== value) begin
            $display("%0t ns: ms_per_minute readback, expected %0d, actual %0d",
                     $time, value, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic queue_item(logic [2:0] mode, logic [31:0] now, logic ff,
                              logic [HOUR_W-1:0] h, logic [MIN_W-1:0] m,
                              logic [HOUR_W-1:0] he);
        clock_cmd_t cmd;
        cmd = '{mode, now, ff, h, m, he};
        items_to_send.push_back(cmd);
        issued_count++;
    endtask

    task automatic wait_idle();
        while (accepted_count != issued_count || clock_reports_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic queue_random_items(int count);
        logic [31:0]       step;
        logic [HOUR_W-1:0] h;
        logic [MIN_W-1:0]  m;
        logic [HOUR_W-1:0] he;
        int                pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            // mostly legal hours and minutes, now and then any bit pattern
            h  = ($urandom_range(0, 4) == 0) ? HOUR_W'($urandom()) : HOUR_W'($urandom_range(0, 23));
            m  = ($urandom_range(0, 4) == 0) ? MIN_W'($urandom()) : MIN_W'($urandom_range(0, 59));
            he = ($urandom_range(0, 4) == 0) ? HOUR_W'($urandom()) : HOUR_W'($urandom_range(0, 23));
            if (pick < 50) begin
                if ($urandom_range(0, 9) == 0 || scale_ms > 32'h0100_0000) begin
                    step = $urandom();
                end else if ($urandom_range(0, 9) == 0) begin
                    step = scale_ms;
                end else begin
                    step = $urandom_range(0, scale_ms + scale_ms / 2 + 2);
                end
                stim_ms = stim_ms + step;
                queue_item(MODE_TICK, stim_ms, $urandom_range(0, 9) == 0, h, m, he);
            end else if (pick < 58) begin
                if ($urandom_range(0, 3) == 0) begin
                    stim_ms = $urandom();
                end
                queue_item(MODE_SET, stim_ms, 1'($urandom()), h, m, he);
            end else if (pick < 66) begin
                queue_item(MODE_STORE, $urandom(), 1'($urandom()), h, m, he);
            end else if (pick < 74) begin
                queue_item(MODE_RESTORE, $urandom(), 1'($urandom()), h, m, he);
            end else if (pick < 84) begin
                queue_item(MODE_UNTIL, $urandom(), 1'($urandom()), h, m, he);
            end else if (pick < 96) begin
                queue_item(MODE_RANGE, $urandom(), 1'($urandom()), h, m, he);
            end else begin
                queue_item($urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7, $urandom(),
                           1'($urandom()), h, m, he);
            end
        end
    endtask

    initial begin
        logic [SCALE_W-1:0] next_scale;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset scale of 1000 ms per minute
        queue_item(MODE_RESTORE, '0, 1'b0, '0, '0, '0);
        queue_item(MODE_TICK, 32'd0, 1'b0, '0, '0, '0);
        queue_item(MODE_TICK, 32'd500, 1'b0, '0, '0, '0);
        queue_item(MODE_TICK, 32'd1000, 1'b0, '0, '0, '0);
        queue_item(MODE_TICK, 32'd1001, 1'b0, '1, '1, '1);
        queue_item(MODE_RANGE, '0, 1'b0, 5'd12, '0, 5'd13);
        queue_item(MODE_RANGE, '0, 1'b0, 5'd20, '0, 5'd2);
        queue_item(MODE_RANGE, '0, 1'b0, 5'd12, '0, 5'd12);
        queue_item(MODE_UNTIL, '0, 1'b0, 5'd12, 6'd0, '0);
        queue_item(MODE_STORE, '1, 1'b1, '1, '1, '1);
        queue_item(MODE_SET, 32'd2000, 1'b0, 5'd23, 6'd59, '0);
        queue_item(MODE_TICK, 32'd2000, 1'b1, '0, '0, '0);
        queue_item(MODE_RESTORE, '0, 1'b0, '0, '0, '0);
        queue_item(MODE_SET, 32'hFFFF_FFF0, 1'b0, '1, '1, '0);
        queue_item(MODE_UNTIL, '0, 1'b0, '0, '0, '0);
        queue_item(MODE_RANGE, '0, 1'b0, '1, '0, '0);
        queue_item(MODE_RANGE, '0, 1'b0, '0, '0, '1);
        queue_item(MODE_TICK, 32'h0000_0010, 1'b0, '0, '0, '0);
        queue_item(MODE_TICK, 32'hFFFF_FFFF, 1'b1, '0, '0, '0);
        queue_item(MODE_SPARE_6, '1, 1'b1, '1, '1, '1);
        queue_item(MODE_SPARE_7, '0, 1'b0, '0, '0, '0);
        wait_idle();

        // zero scale: quotient saturates
        write_scale('0);
        queue_item(MODE_TICK, 32'd5, 1'b0, '0, '0, '0);
        queue_item(MODE_TICK, 32'd5, 1'b1, '0, '0, '0);
        wait_idle();

        write_scale(32'd1);
        queue_item(MODE_TICK, 32'd100, 1'b0, '0, '0, '0);
        queue_item(MODE_TICK, 32'd0, 1'b0, '0, '0, '0);
        wait_idle();

        write_scale('1);
        queue_item(MODE_TICK, 32'hFFFF_FFFF, 1'b0, '0, '0, '0);
        queue_item(MODE_TICK, 32'h8000_0000, 1'b0, '0, '0, '0);
        wait_idle();

        stim_ms = $urandom();
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0:       next_scale = $urandom_range(1, 100);
                1:       next_scale = $urandom_range(101, 100000);
                2:       next_scale = $urandom();
                default: next_scale = $urandom_range(1, 2000);
            endcase
            steady = (ph == 3);
            write_scale(next_scale);
            queue_random_items(60);
            wait_idle();
        end
        steady = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
